// ----- hw/rtl/utf8ci_pkg.sv -----
// Shared types and constants for the UTF-8 code-point-at-index unit.
// No dependencies; every other file in hw/rtl refers to this package.
package utf8ci_pkg;

    // Field widths fixed by the stream format.
    localparam int ByteBits  = 8;
    localparam int IndexBits = 32;
    localparam int CodeBits  = 22;
    localparam int AccBits   = 21;
    localparam int RemBits   = 2;

    // Width of the character counter (range 8 to 64).
    localparam int CountBits = 32;
    // Width at which the counter and the sampled index are compared.
    localparam int CmpBits   = (CountBits > IndexBits) ? CountBits : IndexBits;

    // Lead-byte and continuation-byte patterns.
    localparam logic [ByteBits-1:0] AsciiMask = 8'h80;
    localparam logic [ByteBits-1:0] ContMask  = 8'hC0;
    localparam logic [ByteBits-1:0] ContTag   = 8'h80;
    localparam logic [ByteBits-1:0] Lead2Mask = 8'hE0;
    localparam logic [ByteBits-1:0] Lead2Tag  = 8'hC0;
    localparam logic [ByteBits-1:0] Lead2Data = 8'h1F;
    localparam logic [ByteBits-1:0] Lead3Mask = 8'hF0;
    localparam logic [ByteBits-1:0] Lead3Tag  = 8'hE0;
    localparam logic [ByteBits-1:0] Lead3Data = 8'h0F;
    localparam logic [ByteBits-1:0] Lead4Mask = 8'hF8;
    localparam logic [ByteBits-1:0] Lead4Tag  = 8'hF0;
    localparam logic [ByteBits-1:0] Lead4Data = 8'h07;
    localparam logic [ByteBits-1:0] ContData  = 8'h3F;
    localparam logic [ByteBits-1:0] NulByte   = 8'h00;

    localparam logic [CodeBits-1:0] CodeAbsent = {CodeBits{1'b1}};

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_SEARCH  = 2'd1,
        PH_COLLECT = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [RemBits-1:0]     remaining;
        logic [AccBits-1:0]     accum;
        logic [CodeBits-1:0]    verdict;
        logic [CountBits-1:0]   chars_seen;
        logic [IndexBits-1:0]   target;
    } t_state;

    localparam t_state StateReset = '{
        phase:      PH_START,
        remaining:  '0,
        accum:      '0,
        verdict:    CodeAbsent,
        chars_seen: '0,
        target:     '0
    };

endpackage

// ----- hw/rtl/utf8ci_ifs.sv -----
// Valid/ready channel interfaces for the byte input and the code-point output.
// Depends on utf8ci_pkg for the field widths.
interface utf8ci_byte_if;
    logic                                     valid;
    logic                                     ready;
    logic [utf8ci_pkg::ByteBits-1:0]          text_byte;
    logic signed [utf8ci_pkg::IndexBits-1:0]  query_index;

    modport source (output valid, output text_byte, output query_index, input ready);
    modport sink   (input valid, input text_byte, input query_index, output ready);
endinterface

interface utf8ci_cp_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [utf8ci_pkg::CodeBits-1:0]   code_value;

    modport source (output valid, output code_value, input ready);
    modport sink   (input valid, input code_value, output ready);
endinterface

// ----- hw/rtl/utf8_codepoint_at_index_unit.sv -----
// Top level of the UTF-8 code-point-at-index unit: input register, decode
// state, result register. Depends on utf8ci_pkg, utf8ci_ifs and utf8ci_step.
//
//   Channel   Dir  Payload                                   Moves on
//   i_text    in   text_byte[7:0], query_index[31:0] signed  valid & ready
//   o_code    out  code_value[21:0] signed                   valid & ready
//
// Each byte is taken into an input register, processed by the combinational
// step logic, and the decode state is updated; a transfer can occur on every
// cycle while no NUL waits in the input register. Only the terminating NUL
// produces a result, which is held in the output register once the NUL retires.
// A NUL waits in the input register while an earlier result has not yet been
// taken, so the input stalls only when two results are outstanding.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// decode state to the start of a string.
module utf8_codepoint_at_index_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8ci_byte_if.sink       i_text,
    utf8ci_cp_if.source       o_code
);

    // Input register.
    logic                                   r_in_valid;
    logic [utf8ci_pkg::ByteBits-1:0]        r_in_byte;
    logic [utf8ci_pkg::IndexBits-1:0]       r_in_query;

    // Decode state carried from byte to byte.
    utf8ci_pkg::t_state                     r_state;
    utf8ci_pkg::t_state                     n_state;

    // Result register.
    logic                                   r_out_valid;
    logic [utf8ci_pkg::CodeBits-1:0]        r_out_code;

    logic                                   w_res_valid;
    logic [utf8ci_pkg::CodeBits-1:0]        w_res;
    logic                                   w_out_free;
    logic                                   w_adv;

    utf8ci_step u_step (
        .i_state        (r_state),
        .i_byte         (r_in_byte),
        .i_query        (r_in_query),
        .o_state        (n_state),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    // The registered byte retires unless it is a NUL whose result has
    // nowhere to go yet.
    assign w_out_free = !r_out_valid || o_code.ready;
    assign w_adv      = r_in_valid && (!w_res_valid || w_out_free);

    assign i_text.ready      = !r_in_valid || w_adv;
    assign o_code.valid      = r_out_valid;
    assign o_code.code_value = r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= utf8ci_pkg::StateReset;
        end else begin
            if (i_text.ready) begin
                r_in_valid <= i_text.valid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_code.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte  <= i_text.text_byte;
            r_in_query <= i_text.query_index;
        end
        if (w_adv && w_res_valid) begin
            r_out_code <= w_res;
        end
    end

`ifndef NO_ASSERTIONS
    // A new result only follows the retirement of a NUL byte.
    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_byte == utf8ci_pkg::NulByte))
        else $error("result raised without a retired NUL byte");

    // After a NUL the decoder is back at the start of a string.
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res_valid) |=> (r_state.phase == utf8ci_pkg::PH_START))
        else $error("decoder did not restart after a NUL byte");

    // While collecting, at least one continuation byte is still expected.
    a_collect_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == utf8ci_pkg::PH_COLLECT) |-> (r_state.remaining != '0))
        else $error("collecting with no continuation bytes outstanding");

    // A byte held in the input register is never overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");
`endif

endmodule

// ----- hw/rtl/utf8ci_step.sv -----
// Next-state logic for one string byte: counting, lead-byte decode and
// continuation folding. Depends on utf8ci_pkg.
module utf8ci_step (
    input  utf8ci_pkg::t_state                 i_state,
    input  logic [utf8ci_pkg::ByteBits-1:0]    i_byte,
    input  logic [utf8ci_pkg::IndexBits-1:0]   i_query,
    output utf8ci_pkg::t_state                 o_state,
    output logic                               o_result_valid,
    output logic [utf8ci_pkg::CodeBits-1:0]    o_result
);

    utf8ci_pkg::t_state                s;
    logic                              is_cont;
    logic [utf8ci_pkg::AccBits-1:0]    acc_next;
    logic [utf8ci_pkg::RemBits-1:0]    rem_next;

    always_comb begin
        // The first byte of a string samples the index and clears the rest.
        s = i_state;
        if (i_state.phase == utf8ci_pkg::PH_START) begin
            s = utf8ci_pkg::StateReset;
            s.target = i_query;
            s.phase = i_query[utf8ci_pkg::IndexBits-1] ? utf8ci_pkg::PH_DONE
                                                         : utf8ci_pkg::PH_SEARCH;
        end

        is_cont  = (i_byte & utf8ci_pkg::ContMask) == utf8ci_pkg::ContTag;
        acc_next = {s.accum[utf8ci_pkg::AccBits-7:0], i_byte[5:0]};
        rem_next = s.remaining - utf8ci_pkg::RemBits'(1);

        o_result_valid = (i_byte == utf8ci_pkg::NulByte);
        o_result = (s.phase == utf8ci_pkg::PH_DONE) ? s.verdict : utf8ci_pkg::CodeAbsent;
        o_state  = s;

        if (o_result_valid) begin
            o_state = utf8ci_pkg::StateReset;
        end else begin
            case (s.phase)
                utf8ci_pkg::PH_SEARCH: begin
                    if (!is_cont) begin
                        if (utf8ci_pkg::CmpBits'(s.chars_seen)
                                == utf8ci_pkg::CmpBits'(s.target)) begin
                            if ((i_byte & utf8ci_pkg::AsciiMask) == '0) begin
                                o_state.verdict = utf8ci_pkg::CodeBits'(i_byte);
                                o_state.phase   = utf8ci_pkg::PH_DONE;
                            end else if ((i_byte & utf8ci_pkg::Lead2Mask)
                                         == utf8ci_pkg::Lead2Tag) begin
                                o_state.accum     = utf8ci_pkg::AccBits'(
                                                    i_byte & utf8ci_pkg::Lead2Data);
                                o_state.remaining = utf8ci_pkg::RemBits'(1);
                                o_state.phase     = utf8ci_pkg::PH_COLLECT;
                            end else if ((i_byte & utf8ci_pkg::Lead3Mask)
                                         == utf8ci_pkg::Lead3Tag) begin
                                o_state.accum     = utf8ci_pkg::AccBits'(
                                                    i_byte & utf8ci_pkg::Lead3Data);
                                o_state.remaining = utf8ci_pkg::RemBits'(2);
                                o_state.phase     = utf8ci_pkg::PH_COLLECT;
                            end else if ((i_byte & utf8ci_pkg::Lead4Mask)
                                         == utf8ci_pkg::Lead4Tag) begin
                                o_state.accum     = utf8ci_pkg::AccBits'(
                                                    i_byte & utf8ci_pkg::Lead4Data);
                                o_state.remaining = utf8ci_pkg::RemBits'(3);
                                o_state.phase     = utf8ci_pkg::PH_COLLECT;
                            end else begin
                                o_state.verdict = utf8ci_pkg::CodeAbsent;
                                o_state.phase   = utf8ci_pkg::PH_DONE;
                            end
                        end else if (!(&s.chars_seen)) begin
                            // The counter sticks at its maximum value.
                            o_state.chars_seen = s.chars_seen
                                               + utf8ci_pkg::CountBits'(1);
                        end
                    end
                end
                utf8ci_pkg::PH_COLLECT: begin
                    if (!is_cont) begin
                        o_state.verdict = utf8ci_pkg::CodeAbsent;
                        o_state.phase   = utf8ci_pkg::PH_DONE;
                    end else begin
                        o_state.accum     = acc_next;
                        o_state.remaining = rem_next;
                        if (rem_next == '0) begin
                            o_state.verdict = utf8ci_pkg::CodeBits'(acc_next);
                            o_state.phase   = utf8ci_pkg::PH_DONE;
                        end
                    end
                end
                default: begin
                    o_state = s;
                end
            endcase
        end
    end

endmodule

// ----- test/utf8_codepoint_at_index_unit_tb.sv -----
// Self-checking testbench for utf8_codepoint_at_index_unit: streams strings byte by byte,
// predicts each code point and compares every result transfer in order.
// Depends on utf8ci_pkg, utf8ci_ifs and the unit itself.
module utf8_codepoint_at_index_unit_tb;

    // One byte transfer on the text channel.
    typedef struct {
        logic [utf8ci_pkg::ByteBits-1:0]         text_byte;
        logic signed [utf8ci_pkg::IndexBits-1:0] query_index;
    } t_text_item;

    localparam int RandomBytes = 1650;
    localparam int CycleLimit  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8ci_byte_if text_ch ();
    utf8ci_cp_if   code_ch ();

    utf8_codepoint_at_index_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_code  (code_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bytes still to be sent, and the code points that the strings sent so far must give.
    t_text_item                      pending_bytes[$];
    logic [utf8ci_pkg::ByteBits-1:0] draft[$];
    logic [utf8ci_pkg::CodeBits-1:0] expected_codes[$];
    logic [utf8ci_pkg::CodeBits-1:0] want_code;

    // Our own copy of the decoder state.
    utf8ci_pkg::t_phase               scan_phase;
    logic [utf8ci_pkg::CountBits-1:0] scan_count;
    logic [utf8ci_pkg::IndexBits-1:0] scan_target;
    logic [utf8ci_pkg::RemBits-1:0]   scan_left;
    logic [utf8ci_pkg::AccBits-1:0]   scan_accum;
    logic [utf8ci_pkg::CodeBits-1:0]  scan_answer;

    int send_gap;
    int take_stall;
    bit send_steady;
    bit take_steady;
    int mismatches;
    int codes_checked;
    int strings_sent;
    int bytes_sent;
    int directed_items;
    int cycle_count;

    function automatic void clear_scan();
        scan_phase  = utf8ci_pkg::PH_START;
        scan_count  = '0;
        scan_target = '0;
        scan_left   = '0;
        scan_accum  = '0;
        scan_answer = utf8ci_pkg::CodeAbsent;
    endfunction

    // Advances the decoder copy by one accepted byte. The NUL pushes the code point
    // that the unit must return for the string it ends.
    function automatic void absorb_text_byte(input logic [utf8ci_pkg::ByteBits-1:0] b,
                                             input logic [utf8ci_pkg::IndexBits-1:0] q);
        logic [utf8ci_pkg::CmpBits-1:0] seen_wide;
        logic [utf8ci_pkg::CmpBits-1:0] want_wide;
        if (scan_phase == utf8ci_pkg::PH_START) begin
            clear_scan();
            scan_target = q;
            // A negative index can never match, so the answer is settled at once.
            scan_phase  = q[utf8ci_pkg::IndexBits-1] ? utf8ci_pkg::PH_DONE
                                                     : utf8ci_pkg::PH_SEARCH;
        end
        seen_wide = utf8ci_pkg::CmpBits'(scan_count);
        want_wide = utf8ci_pkg::CmpBits'(scan_target);
        if (b == utf8ci_pkg::NulByte) begin
            // Still searching or collecting at the NUL means nothing valid was found.
            expected_codes.push_back((scan_phase == utf8ci_pkg::PH_DONE)
                                     ? scan_answer : utf8ci_pkg::CodeAbsent);
            clear_scan();
        end else if (scan_phase == utf8ci_pkg::PH_SEARCH) begin
            if ((b & utf8ci_pkg::ContMask) != utf8ci_pkg::ContTag) begin
                if (seen_wide == want_wide) begin
                    if ((b & utf8ci_pkg::AsciiMask) == '0) begin
                        scan_answer = utf8ci_pkg::CodeBits'(b);
                        scan_phase  = utf8ci_pkg::PH_DONE;
                    end else if ((b & utf8ci_pkg::Lead2Mask) == utf8ci_pkg::Lead2Tag) begin
                        scan_accum = utf8ci_pkg::AccBits'(b & utf8ci_pkg::Lead2Data);
                        scan_left  = 2'd1;
                        scan_phase = utf8ci_pkg::PH_COLLECT;
                    end else if ((b & utf8ci_pkg::Lead3Mask) == utf8ci_pkg::Lead3Tag) begin
                        scan_accum = utf8ci_pkg::AccBits'(b & utf8ci_pkg::Lead3Data);
                        scan_left  = 2'd2;
                        scan_phase = utf8ci_pkg::PH_COLLECT;
                    end else if ((b & utf8ci_pkg::Lead4Mask) == utf8ci_pkg::Lead4Tag) begin
                        scan_accum = utf8ci_pkg::AccBits'(b & utf8ci_pkg::Lead4Data);
                        scan_left  = 2'd3;
                        scan_phase = utf8ci_pkg::PH_COLLECT;
                    end else begin
                        scan_answer = utf8ci_pkg::CodeAbsent;
                        scan_phase  = utf8ci_pkg::PH_DONE;
                    end
                end else if (scan_count != '1) begin
                    scan_count++;
                end
            end
        end else if (scan_phase == utf8ci_pkg::PH_COLLECT) begin
            if ((b & utf8ci_pkg::ContMask) != utf8ci_pkg::ContTag) begin
                scan_answer = utf8ci_pkg::CodeAbsent;
                scan_phase  = utf8ci_pkg::PH_DONE;
            end else begin
                scan_accum = {scan_accum[utf8ci_pkg::AccBits-7:0], b[5:0]};
                scan_left  = scan_left - utf8ci_pkg::RemBits'(1);
                if (scan_left == '0) begin
                    scan_answer = {1'b0, scan_accum};
                    scan_phase  = utf8ci_pkg::PH_DONE;
                end
            end
        end
    endfunction

    function automatic void report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    // Queues the drafted string and its NUL. Only the first byte carries the wanted
    // index; the rest carry noise, which the unit must not look at.
    function automatic void ship_draft(input logic signed [utf8ci_pkg::IndexBits-1:0] idx);
        t_text_item it;
        foreach (draft[k]) begin
            it.text_byte   = draft[k];
            it.query_index = (k == 0) ? idx : $urandom();
            pending_bytes.push_back(it);
        end
        it.text_byte   = utf8ci_pkg::NulByte;
        it.query_index = (draft.size() == 0) ? idx : $urandom();
        pending_bytes.push_back(it);
    endfunction

    // Directed strings of up to four bytes, packed from the most significant byte.
    task automatic directed_string(input logic [31:0] body, input int len,
                                   input logic signed [utf8ci_pkg::IndexBits-1:0] idx);
        draft.delete();
        for (int k = 0; k < len; k++) draft.push_back(body[31-8*k -: 8]);
        ship_draft(idx);
    endtask

    // Mostly well-formed UTF-8 with random content; some stray bytes, cut-short
    // sequences and whole strings of noise.
    function automatic void add_random_string();
        int n_chars;
        int kind;
        int seq_len;
        int keep;
        int n_starts;
        int pick;
        logic signed [utf8ci_pkg::IndexBits-1:0] idx;
        draft.delete();
        if ($urandom_range(0, 9) == 0) begin
            n_chars = $urandom_range(0, 12);
            repeat (n_chars) draft.push_back(8'($urandom_range(1, 255)));
        end else begin
            n_chars = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(0, 8);
            repeat (n_chars) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    draft.push_back(8'($urandom_range(1, 127)));
                end else if (kind == 8) begin
                    draft.push_back(8'($urandom_range(1, 255)));
                end else begin
                    seq_len = (kind <= 5) ? 2 : (kind == 6) ? 3 : (kind == 7) ? 4
                                                            : $urandom_range(2, 4);
                    // A broken sequence loses at least one continuation byte.
                    keep = (kind == 9) ? $urandom_range(0, seq_len - 2) : seq_len - 1;
                    case (seq_len)
                        2:       draft.push_back(utf8ci_pkg::Lead2Tag
                                                 | (8'($urandom()) & utf8ci_pkg::Lead2Data));
                        3:       draft.push_back(utf8ci_pkg::Lead3Tag
                                                 | (8'($urandom()) & utf8ci_pkg::Lead3Data));
                        default: draft.push_back(utf8ci_pkg::Lead4Tag
                                                 | (8'($urandom()) & utf8ci_pkg::Lead4Data));
                    endcase
                    repeat (keep) draft.push_back(utf8ci_pkg::ContTag
                                                  | (8'($urandom()) & utf8ci_pkg::ContData));
                    if (kind == 9 && $urandom_range(0, 1) == 1)
                        draft.push_back(8'($urandom_range(1, 127)));
                end
            end
        end
        n_starts = 0;
        foreach (draft[k]) if ((draft[k] & utf8ci_pkg::ContMask) != utf8ci_pkg::ContTag)
            n_starts++;
        // Most indexes land on a character or just past the end.
        pick = $urandom_range(0, 99);
        if (pick < 70)      idx = $urandom_range(0, n_starts);
        else if (pick < 75) idx = 0 - $urandom_range(1, 4);
        else if (pick < 82) idx = $urandom() | 32'h8000_0000;
        else if (pick < 90) idx = $urandom();
        else                idx = $urandom_range(0, 30);
        ship_draft(idx);
    endfunction

    // Driver: presents the front of the queue, holds it until the transfer, then
    // waits the drawn gap. Stretches without gaps come and go at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (text_ch.valid && text_ch.ready) begin
                absorb_text_byte(text_ch.text_byte, text_ch.query_index);
                bytes_sent++;
                if (text_ch.text_byte == utf8ci_pkg::NulByte) strings_sent++;
                void'(pending_bytes.pop_front());
                if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 15);
            end
            if (!text_ch.valid || text_ch.ready) begin
                if (send_gap > 0 || pending_bytes.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    text_ch.valid <= 1'b0;
                end else begin
                    text_ch.valid       <= 1'b1;
                    text_ch.text_byte   <= pending_bytes[0].text_byte;
                    text_ch.query_index <= pending_bytes[0].query_index;
                end
            end
        end
    end

    // Monitor: checks every result transfer against the oldest expectation and
    // then holds ready low for a drawn stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_ch.ready <= 1'b0;
            take_stall = 0;
        end else begin
            if (code_ch.valid && code_ch.ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("code_value %h with no string outstanding",
                                              code_ch.code_value));
                end else begin
                    want_code = expected_codes.pop_front();
                    codes_checked++;
                    if (code_ch.code_value !== want_code)
                        report_mismatch($sformatf("code_value %h, expected %h",
                                                  code_ch.code_value, want_code));
                end
                if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
                take_stall = take_steady ? 0 : $urandom_range(0, 15);
            end
            if (take_stall > 0) begin
                take_stall--;
                code_ch.ready <= 1'b0;
            end else begin
                code_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timed out: %0d bytes unsent, %0d code points outstanding",
                     pending_bytes.size(), expected_codes.size());
            $display("[utf8_codepoint_at_index_unit] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        clear_scan();

        // Directed strings: boundary indexes, every sequence length, the largest
        // code point, and each way a lookup can fail.
        directed_string(32'h4100_0000, 1, 32'sh8000_0000);  // negative index
        directed_string(32'hEFBF_BF00, 3, 0);               // three-byte sequence
        directed_string(32'hF7BF_BFBF, 4, 0);               // largest four-byte value
        directed_string(32'hFF00_0000, 1, 0);               // unknown lead byte
        directed_string(32'hC341_0000, 2, 0);               // wrong continuation byte
        directed_string(32'hE282_0000, 2, 0);               // NUL cuts the sequence
        directed_string(32'h6100_0000, 1, 32'sh7FFF_FFFF);  // index past the end
        directed_string(32'hC3A9_7A00, 3, 0);               // two-byte, then ignored byte
        directed_items = pending_bytes.size();

        while (pending_bytes.size() < directed_items + RandomBytes) add_random_string();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled away from the rising edge so the queues are settled.
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || text_ch.valid || expected_codes.size() != 0);
        // The result register is written when the NUL retires; leave room for strays.
        repeat (8) @(negedge i_clk);

        $display("%0d strings in %0d bytes sent, %0d code points checked, %0d mismatches",
                 strings_sent, bytes_sent, codes_checked, mismatches);
        if (mismatches == 0) begin
            $display("[utf8_codepoint_at_index_unit] OK");
        end else begin
            $display("[utf8_codepoint_at_index_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/utf8ci_pkg.sv
hw/rtl/utf8ci_ifs.sv
hw/rtl/utf8ci_step.sv
hw/rtl/utf8_codepoint_at_index_unit.sv
test/utf8_codepoint_at_index_unit_tb.sv
